>>> sv/rmms_pkg.sv
package rmms_pkg;

   localparam int MAX_SAMPLES_DEF = 64;
   localparam int SAMPLE_W = 32;

   localparam logic [1:0] STATUS_OK = 2'd0;
   localparam logic [1:0] STATUS_FEW = 2'd1;
   localparam logic [1:0] STATUS_NONE = 2'd2;
   localparam logic [1:0] STATUS_OVF = 2'd3;

   typedef enum logic [3:0] {
      B_IDLE,
      B_MEAN,
      B_MEAN_W,
      B_MCAND,
      B_MCAPT,
      B_MSWEEP,
      B_MFIN,
      B_VSWEEP,
      B_VDIV,
      B_VDIV_W,
      B_SQRT_W,
      B_RSWEEP,
      B_RDIV,
      B_RDIV_W,
      B_DONE
   } back_state_type;

   typedef struct packed {
      logic busy;
      logic bank;
   } back_stat_type;

endpackage

>>> sv/rmms_ram.sv
module rmms_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

>>> sv/rmms_div.sv
module rmms_div #(
   parameter int DW = 71,
   parameter int CW = 7
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [DW-1:0] dividend,
   input  logic [CW-1:0] divisor,
   output logic          done,
   output logic [DW-1:0] quotient
);

   localparam int NW = $clog2(DW + 1);

   logic [DW-1:0] quo_ff, quo_in;
   logic [CW-1:0] rem_ff, rem_in;
   logic [CW-1:0] dv_ff, dv_in;
   logic [NW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [CW:0]   rem_sh;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dv_ff  <= dv_in;
   end

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dv_in   = dv_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      rem_sh  = {rem_ff, quo_ff[DW-1]};
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dv_in   = divisor;
         cnt_in  = NW'(DW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (rem_sh >= {1'b0, dv_ff}) begin
            rem_in = CW'(rem_sh - {1'b0, dv_ff});
            quo_in = {quo_ff[DW-2:0], 1'b1};
         end else begin
            rem_in = rem_sh[CW-1:0];
            quo_in = {quo_ff[DW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == NW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   assign done = done_ff;
   assign quotient = quo_ff;

endmodule

>>> sv/rmms_sqrt.sv
module rmms_sqrt (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] value,
   output logic        done,
   output logic [31:0] root
);

   logic [63:0] val_ff, val_in;
   logic [33:0] rem_ff, rem_in;
   logic [31:0] root_ff, root_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [33:0] rem_sh;
   logic [33:0] trial;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      val_ff  <= val_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   always_comb begin
      val_in  = val_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      rem_sh  = {rem_ff[31:0], val_ff[63:62]};
      trial   = {root_ff, 2'b01};
      if (start) begin
         val_in  = value;
         rem_in  = '0;
         root_in = '0;
         cnt_in  = 6'd32;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         val_in = {val_ff[61:0], 2'b00};
         if (rem_sh >= trial) begin
            rem_in  = rem_sh - trial;
            root_in = {root_ff[30:0], 1'b1};
         end else begin
            rem_in  = rem_sh;
            root_in = {root_ff[30:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

>>> sv/rmms_front.sv
module rmms_front
   import rmms_pkg::*;
#(
   parameter int MAX_SAMPLES = MAX_SAMPLES_DEF,
   parameter int CW = $clog2(MAX_SAMPLES + 1),
   parameter int AW = $clog2(MAX_SAMPLES),
   parameter int SW = SAMPLE_W + CW
) (
   input  logic                clock,
   input  logic                reset,
   input  logic [SAMPLE_W-1:0] req_sample,
   input  logic                req_last,
   input  logic                req_push,
   output logic                req_full,
   output logic                ram_we,
   output logic [AW:0]         ram_waddr,
   output logic [SAMPLE_W-1:0] ram_wdata,
   output logic                job_valid,
   output logic [CW-1:0]       job_count,
   output logic [SW-1:0]       job_sum,
   output logic                job_ovf,
   output logic                job_bank,
   input  logic                job_take,
   input  back_stat_type       back_stat
);

   logic [CW-1:0] cnt_ff, cnt_in;
   logic [SW-1:0] sum_ff, sum_in;
   logic          ovf_ff, ovf_in;
   logic          wb_ff, wb_in;
   logic          jv_ff, jv_in;
   logic [CW-1:0] jc_ff, jc_in;
   logic [SW-1:0] js_ff, js_in;
   logic          jo_ff, jo_in;
   logic          jb_ff, jb_in;
   logic          accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         sum_ff <= '0;
         ovf_ff <= 1'b0;
         wb_ff  <= 1'b0;
         jv_ff  <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         sum_ff <= sum_in;
         ovf_ff <= ovf_in;
         wb_ff  <= wb_in;
         jv_ff  <= jv_in;
      end
      jc_ff <= jc_in;
      js_ff <= js_in;
      jo_ff <= jo_in;
      jb_ff <= jb_in;
   end

   assign req_full = jv_ff || (back_stat.busy && (back_stat.bank == wb_ff));
   assign accept = req_push && !req_full;

   always_comb begin
      cnt_in = cnt_ff;
      sum_in = sum_ff;
      ovf_in = ovf_ff;
      wb_in  = wb_ff;
      jv_in  = jv_ff && !job_take;
      jc_in  = jc_ff;
      js_in  = js_ff;
      jo_in  = jo_ff;
      jb_in  = jb_ff;
      ram_we = 1'b0;
      if (accept) begin
         if (cnt_ff < CW'(MAX_SAMPLES)) begin
            ram_we = 1'b1;
            cnt_in = cnt_ff + 1'b1;
            sum_in = sum_ff + SW'(req_sample);
         end else begin
            ovf_in = 1'b1;
         end
         if (req_last) begin
            jv_in  = 1'b1;
            jc_in  = cnt_in;
            js_in  = sum_in;
            jo_in  = ovf_in;
            jb_in  = wb_ff;
            cnt_in = '0;
            sum_in = '0;
            ovf_in = 1'b0;
            wb_in  = !wb_ff;
         end
      end
   end

   assign ram_waddr = {wb_ff, cnt_ff[AW-1:0]};
   assign ram_wdata = req_sample;
   assign job_valid = jv_ff;
   assign job_count = jc_ff;
   assign job_sum = js_ff;
   assign job_ovf = jo_ff;
   assign job_bank = jb_ff;

endmodule

>>> sv/rmms_back.sv
module rmms_back
   import rmms_pkg::*;
#(
   parameter int MAX_SAMPLES = MAX_SAMPLES_DEF,
   parameter int CW = $clog2(MAX_SAMPLES + 1),
   parameter int AW = $clog2(MAX_SAMPLES),
   parameter int SW = SAMPLE_W + CW
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                job_valid,
   input  logic [CW-1:0]       job_count,
   input  logic [SW-1:0]       job_sum,
   input  logic                job_ovf,
   input  logic                job_bank,
   output logic                job_take,
   output back_stat_type       back_stat,
   output logic [AW:0]         ram_raddr,
   input  logic [SAMPLE_W-1:0] ram_rdata,
   output logic [SAMPLE_W-1:0] rsp_robust_mean,
   output logic [SAMPLE_W-1:0] rsp_mean_value,
   output logic [SAMPLE_W-1:0] rsp_std_dev,
   output logic [SAMPLE_W-1:0] rsp_median_value,
   output logic [CW-1:0]       rsp_accepted_count,
   output logic [CW-1:0]       rsp_sample_count,
   output logic [1:0]          rsp_status,
   output logic                rsp_empty,
   input  logic                rsp_pop
);

   localparam int SSW = 2 * SAMPLE_W + CW;

   back_state_type state_ff, state_in;
   logic [CW-1:0]  n_ff, n_in;
   logic [SW-1:0]  sum_ff, sum_in;
   logic           ovf_ff, ovf_in;
   logic           bank_ff, bank_in;
   logic [31:0]    mean_ff, mean_in;
   logic [31:0]    med_ff, med_in;
   logic [31:0]    v0_ff, v0_in;
   logic [31:0]    v1_ff, v1_in;
   logic [31:0]    cand_ff, cand_in;
   logic [CW-1:0]  oi_ff, oi_in;
   logic [CW-1:0]  ri_ff, ri_in;
   logic           rv_ff, rv_in;
   logic [CW-1:0]  lt_ff, lt_in;
   logic [CW-1:0]  le_ff, le_in;
   logic [31:0]    d_ff, d_in;
   logic           dv_ff, dv_in;
   logic [63:0]    sq_ff, sq_in;
   logic           sqv_ff, sqv_in;
   logic [SSW-1:0] ss_ff, ss_in;
   logic [31:0]    sd_ff, sd_in;
   logic [SW-1:0]  asum_ff, asum_in;
   logic [CW-1:0]  acc_ff, acc_in;
   logic [31:0]    robust_ff, robust_in;
   logic           ov_ff, ov_in;
   logic [31:0]    o_robust_ff, o_robust_in;
   logic [31:0]    o_mean_ff, o_mean_in;
   logic [31:0]    o_sd_ff, o_sd_in;
   logic [31:0]    o_med_ff, o_med_in;
   logic [CW-1:0]  o_acc_ff, o_acc_in;
   logic [CW-1:0]  o_n_ff, o_n_in;
   logic [1:0]     o_st_ff, o_st_in;

   logic           div_start;
   logic [SSW-1:0] div_dividend;
   logic [CW-1:0]  div_divisor;
   logic           div_done;
   logic [SSW-1:0] div_quo;
   logic           sqrt_start;
   logic [63:0]    sqrt_value;
   logic           sqrt_done;
   logic [31:0]    sqrt_root;
   logic           issue;
   logic [CW-1:0]  k0;
   logic [CW-1:0]  k1;
   logic [31:0]    diff_mean;
   logic [31:0]    diff_med;

   rmms_div #(.DW(SSW), .CW(CW)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quo)
   );

   rmms_sqrt u_sqrt (
      .clock (clock),
      .reset (reset),
      .start (sqrt_start),
      .value (sqrt_value),
      .done  (sqrt_done),
      .root  (sqrt_root)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
         ov_ff    <= 1'b0;
         rv_ff    <= 1'b0;
         dv_ff    <= 1'b0;
         sqv_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         ov_ff    <= ov_in;
         rv_ff    <= rv_in;
         dv_ff    <= dv_in;
         sqv_ff   <= sqv_in;
      end
      n_ff        <= n_in;
      sum_ff      <= sum_in;
      ovf_ff      <= ovf_in;
      bank_ff     <= bank_in;
      mean_ff     <= mean_in;
      med_ff      <= med_in;
      v0_ff       <= v0_in;
      v1_ff       <= v1_in;
      cand_ff     <= cand_in;
      oi_ff       <= oi_in;
      ri_ff       <= ri_in;
      lt_ff       <= lt_in;
      le_ff       <= le_in;
      d_ff        <= d_in;
      sq_ff       <= sq_in;
      ss_ff       <= ss_in;
      sd_ff       <= sd_in;
      asum_ff     <= asum_in;
      acc_ff      <= acc_in;
      robust_ff   <= robust_in;
      o_robust_ff <= o_robust_in;
      o_mean_ff   <= o_mean_in;
      o_sd_ff     <= o_sd_in;
      o_med_ff    <= o_med_in;
      o_acc_ff    <= o_acc_in;
      o_n_ff      <= o_n_in;
      o_st_ff     <= o_st_in;
   end

   assign k0 = (n_ff - 1'b1) >> 1;
   assign k1 = n_ff >> 1;
   assign diff_mean = (ram_rdata >= mean_ff) ? ram_rdata - mean_ff : mean_ff - ram_rdata;
   assign diff_med = (ram_rdata >= med_ff) ? ram_rdata - med_ff : med_ff - ram_rdata;

   always_comb begin
      state_in     = state_ff;
      n_in         = n_ff;
      sum_in       = sum_ff;
      ovf_in       = ovf_ff;
      bank_in      = bank_ff;
      mean_in      = mean_ff;
      med_in       = med_ff;
      v0_in        = v0_ff;
      v1_in        = v1_ff;
      cand_in      = cand_ff;
      oi_in        = oi_ff;
      ri_in        = ri_ff;
      rv_in        = 1'b0;
      lt_in        = lt_ff;
      le_in        = le_ff;
      d_in         = diff_mean;
      dv_in        = 1'b0;
      sq_in        = d_ff * d_ff;
      sqv_in       = 1'b0;
      ss_in        = ss_ff;
      sd_in        = sd_ff;
      asum_in      = asum_ff;
      acc_in       = acc_ff;
      robust_in    = robust_ff;
      ov_in        = ov_ff && !rsp_pop;
      o_robust_in  = o_robust_ff;
      o_mean_in    = o_mean_ff;
      o_sd_in      = o_sd_ff;
      o_med_in     = o_med_ff;
      o_acc_in     = o_acc_ff;
      o_n_in       = o_n_ff;
      o_st_in      = o_st_ff;
      job_take     = 1'b0;
      div_start    = 1'b0;
      div_dividend = ss_ff;
      div_divisor  = n_ff;
      sqrt_start   = 1'b0;
      sqrt_value   = '1;
      issue        = ri_ff < n_ff;
      ram_raddr    = {bank_ff, ri_ff[AW-1:0]};
      unique case (state_ff)
         B_IDLE: begin
            if (job_valid) begin
               job_take  = 1'b1;
               n_in      = job_count;
               sum_in    = job_sum;
               ovf_in    = job_ovf;
               bank_in   = job_bank;
               mean_in   = '0;
               med_in    = '0;
               sd_in     = '0;
               robust_in = '0;
               acc_in    = '0;
               asum_in   = '0;
               ss_in     = '0;
               oi_in     = '0;
               state_in  = (job_count == '0) ? B_DONE : B_MEAN;
            end
         end
         B_MEAN: begin
            div_start    = 1'b1;
            div_dividend = SSW'(sum_ff);
            state_in     = B_MEAN_W;
         end
         B_MEAN_W: begin
            if (div_done) begin
               mean_in  = div_quo[31:0];
               state_in = B_MCAND;
            end
         end
         B_MCAND: begin
            ram_raddr = {bank_ff, oi_ff[AW-1:0]};
            state_in  = B_MCAPT;
         end
         B_MCAPT: begin
            cand_in  = ram_rdata;
            lt_in    = '0;
            le_in    = '0;
            ri_in    = '0;
            state_in = B_MSWEEP;
         end
         B_MSWEEP: begin
            rv_in = issue;
            if (issue) begin
               ri_in = ri_ff + 1'b1;
            end
            if (rv_ff) begin
               lt_in = lt_ff + CW'(ram_rdata < cand_ff);
               le_in = le_ff + CW'(ram_rdata <= cand_ff);
            end
            if (!issue && !rv_ff) begin
               if (lt_ff <= k0 && k0 < le_ff) begin
                  v0_in = cand_ff;
               end
               if (lt_ff <= k1 && k1 < le_ff) begin
                  v1_in = cand_ff;
               end
               oi_in    = oi_ff + 1'b1;
               state_in = (oi_in == n_ff) ? B_MFIN : B_MCAND;
            end
         end
         B_MFIN: begin
            med_in   = n_ff[0] ? v0_ff : 32'(({1'b0, v0_ff} + {1'b0, v1_ff}) >> 1);
            ri_in    = '0;
            state_in = (n_ff < CW'(2)) ? B_DONE : B_VSWEEP;
         end
         B_VSWEEP: begin
            rv_in  = issue;
            dv_in  = rv_ff;
            sqv_in = dv_ff;
            if (issue) begin
               ri_in = ri_ff + 1'b1;
            end
            if (sqv_ff) begin
               ss_in = ss_ff + SSW'(sq_ff);
            end
            if (!issue && !rv_ff && !dv_ff && !sqv_ff) begin
               state_in = B_VDIV;
            end
         end
         B_VDIV: begin
            div_start   = 1'b1;
            div_divisor = n_ff - 1'b1;
            state_in    = B_VDIV_W;
         end
         B_VDIV_W: begin
            div_divisor = n_ff - 1'b1;
            if (div_done) begin
               sqrt_start = 1'b1;
               sqrt_value = (|div_quo[SSW-1:64]) ? '1 : div_quo[63:0];
               state_in   = B_SQRT_W;
            end
         end
         B_SQRT_W: begin
            if (sqrt_done) begin
               sd_in    = sqrt_root;
               ri_in    = '0;
               state_in = B_RSWEEP;
            end
         end
         B_RSWEEP: begin
            rv_in = issue;
            if (issue) begin
               ri_in = ri_ff + 1'b1;
            end
            if (rv_ff && diff_med < sd_ff) begin
               asum_in = asum_ff + SW'(ram_rdata);
               acc_in  = acc_ff + 1'b1;
            end
            if (!issue && !rv_ff) begin
               state_in = B_RDIV;
            end
         end
         B_RDIV: begin
            div_dividend = SSW'(asum_ff);
            div_divisor  = acc_ff;
            if (acc_ff == '0) begin
               state_in = B_DONE;
            end else begin
               div_start = 1'b1;
               state_in  = B_RDIV_W;
            end
         end
         B_RDIV_W: begin
            if (div_done) begin
               robust_in = div_quo[31:0];
               state_in  = B_DONE;
            end
         end
         B_DONE: begin
            if (!ov_ff) begin
               ov_in       = 1'b1;
               o_robust_in = robust_ff;
               o_mean_in   = mean_ff;
               o_sd_in     = sd_ff;
               o_med_in    = med_ff;
               o_acc_in    = acc_ff;
               o_n_in      = n_ff;
               priority if (n_ff < CW'(2)) begin
                  o_st_in = STATUS_FEW;
               end else if (ovf_ff) begin
                  o_st_in = STATUS_OVF;
               end else if (acc_ff == '0) begin
                  o_st_in = STATUS_NONE;
               end else begin
                  o_st_in = STATUS_OK;
               end
               state_in = B_IDLE;
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   assign back_stat.busy = (state_ff != B_IDLE);
   assign back_stat.bank = bank_ff;
   assign rsp_robust_mean = o_robust_ff;
   assign rsp_mean_value = o_mean_ff;
   assign rsp_std_dev = o_sd_ff;
   assign rsp_median_value = o_med_ff;
   assign rsp_accepted_count = o_acc_ff;
   assign rsp_sample_count = o_n_ff;
   assign rsp_status = o_st_ff;
   assign rsp_empty = !ov_ff;

endmodule

>>> sv/robust_mean_median_stddev.sv
// Samples are taken one per cycle while req_full is low; req_full rises while a closed set still
// waits to be taken, or while the back end works on the bank that new samples would enter.
// The median search compares every stored sample with every stored sample.
// The store has two banks, so the next set loads while the previous one is worked on.
// Reset clears the control state and the set in progress; the sample store is not cleared.
module robust_mean_median_stddev
   import rmms_pkg::*;
#(
   parameter int MAX_SAMPLES = MAX_SAMPLES_DEF,
   parameter int CW = $clog2(MAX_SAMPLES + 1)
) (
   input  logic                clock,
   input  logic                reset,
   input  logic [SAMPLE_W-1:0] req_sample,
   input  logic                req_last,
   input  logic                req_push,
   output logic                req_full,
   output logic [SAMPLE_W-1:0] rsp_robust_mean,
   output logic [SAMPLE_W-1:0] rsp_mean_value,
   output logic [SAMPLE_W-1:0] rsp_std_dev,
   output logic [SAMPLE_W-1:0] rsp_median_value,
   output logic [CW-1:0]       rsp_accepted_count,
   output logic [CW-1:0]       rsp_sample_count,
   output logic [1:0]          rsp_status,
   output logic                rsp_empty,
   input  logic                rsp_pop
);

   localparam int AW = $clog2(MAX_SAMPLES);
   localparam int SW = SAMPLE_W + CW;

   logic                ram_we;
   logic [AW:0]         ram_waddr;
   logic [SAMPLE_W-1:0] ram_wdata;
   logic [AW:0]         ram_raddr;
   logic [SAMPLE_W-1:0] ram_rdata;
   logic                job_valid;
   logic [CW-1:0]       job_count;
   logic [SW-1:0]       job_sum;
   logic                job_ovf;
   logic                job_bank;
   logic                job_take;
   back_stat_type       back_stat;

   rmms_ram #(.WIDTH(SAMPLE_W), .DEPTH(2 ** (AW + 1))) u_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   rmms_front #(.MAX_SAMPLES(MAX_SAMPLES), .CW(CW), .AW(AW), .SW(SW)) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_sample (req_sample),
      .req_last   (req_last),
      .req_push   (req_push),
      .req_full   (req_full),
      .ram_we     (ram_we),
      .ram_waddr  (ram_waddr),
      .ram_wdata  (ram_wdata),
      .job_valid  (job_valid),
      .job_count  (job_count),
      .job_sum    (job_sum),
      .job_ovf    (job_ovf),
      .job_bank   (job_bank),
      .job_take   (job_take),
      .back_stat  (back_stat)
   );

   rmms_back #(.MAX_SAMPLES(MAX_SAMPLES), .CW(CW), .AW(AW), .SW(SW)) u_back (
      .clock              (clock),
      .reset              (reset),
      .job_valid          (job_valid),
      .job_count          (job_count),
      .job_sum            (job_sum),
      .job_ovf            (job_ovf),
      .job_bank           (job_bank),
      .job_take           (job_take),
      .back_stat          (back_stat),
      .ram_raddr          (ram_raddr),
      .ram_rdata          (ram_rdata),
      .rsp_robust_mean    (rsp_robust_mean),
      .rsp_mean_value     (rsp_mean_value),
      .rsp_std_dev        (rsp_std_dev),
      .rsp_median_value   (rsp_median_value),
      .rsp_accepted_count (rsp_accepted_count),
      .rsp_sample_count   (rsp_sample_count),
      .rsp_status         (rsp_status),
      .rsp_empty          (rsp_empty),
      .rsp_pop            (rsp_pop)
   );

endmodule
